// ===== rtl/superfast_string_hash_core_defines.svh =====
// Assertion macros for the string hash core.
// Included by superfast_string_hash_core.sv; no other dependencies.
`ifndef SUPERFAST_STRING_HASH_CORE_DEFINES_SVH
`define SUPERFAST_STRING_HASH_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFH_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SFH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sfh_pkg.sv =====
// Package for the string hash core: field widths, shift amounts and
// the chunk, tail and avalanche mixing functions. No dependencies.
package sfh_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned CountW = 3;
    localparam int unsigned HashW  = 32;
    localparam int unsigned InW    = 4 * ByteW + CountW;
    localparam int unsigned InTdW  = ((InW + 7) / 8) * 8;

    localparam int unsigned ShA = 11;
    localparam int unsigned ShB = 16;
    localparam int unsigned ShC = 18;
    localparam int unsigned ShD = 17;
    localparam int unsigned ShE = 15;

    typedef logic [ByteW-1:0]  t_byte;
    typedef logic [CountW-1:0] t_count;
    typedef logic [HashW-1:0]  t_hash;

    function automatic t_hash pair16(input t_byte hi, input t_byte lo);
        pair16 = {16'b0, hi, lo};
    endfunction

    function automatic t_hash mix_chunk(input t_hash h_in, input t_byte b0,
                                        input t_byte b1, input t_byte b2,
                                        input t_byte b3);
        t_hash h;
        t_hash t;
        h = h_in + pair16(b0, b1);
        t = (pair16(b2, b3) << ShA) ^ h;
        h = (h << ShB) ^ t;
        h = h + (h >> ShA);
        mix_chunk = h;
    endfunction

    // Tail of one to three bytes; a count of zero leaves the hash alone.
    function automatic t_hash mix_tail(input t_hash h_in, input logic [1:0] n,
                                       input t_byte b0, input t_byte b1,
                                       input t_byte b2);
        t_hash h;
        h = h_in;
        case (n)
            2'd3: begin
                h = h + pair16(b0, b1);
                h = h ^ (h << ShB);
                h = h ^ ({24'b0, b2} << ShC);
                h = h + (h >> ShA);
            end
            2'd2: begin
                h = h + pair16(b0, b1);
                h = h ^ (h << ShA);
                h = h + (h >> ShD);
            end
            2'd1: begin
                h = h + {24'b0, b0};
                h = h ^ (h << 10);
                h = h + (h >> 1);
            end
            default: begin
                h = h_in;
            end
        endcase
        mix_tail = h;
    endfunction

    function automatic t_hash avalanche(input t_hash h_in);
        t_hash h;
        h = h_in ^ (h_in << 3);
        h = h + (h >> 5);
        h = h ^ (h << 2);
        h = h + (h >> ShE);
        h = h ^ (h << 10);
        avalanche = h;
    endfunction

endpackage

// ===== rtl/superfast_string_hash_core.sv =====
// Top level of the string hash core: input register, mixing logic, result register.
// Depends on sfh_pkg and superfast_string_hash_core_defines.svh.
//
// Hashes a byte string that arrives four bytes per item into a 32-bit value.
// One item is taken per clock cycle when the output is not stalled; an accepted
// last item goes through the input register, then its hash through the result
// register to m_axis. Each item is registered, then mixed into the running hash
// combinationally (the running-hash feedback loop sets the item rate). Full chunks
// (byte_count 4, or 5..7 which count as 4) are mixed; a non-last item with fewer
// than four bytes is dropped without effect. On tlast the full chunk or the 0..3
// byte tail is mixed, the avalanche runs, the hash is emitted and the running
// hash clears. An empty last item emits the avalanche of the running hash, so an
// empty string hashes to 0. Items without tlast never wait on the output side.
`include "superfast_string_hash_core_defines.svh"

module superfast_string_hash_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // [7:0] first_byte, [15:8] second_byte, [23:16] third_byte,
    // [31:24] fourth_byte, [34:32] byte_count, [39:35] zero
    input  logic [sfh_pkg::InTdW-1:0] s_axis_tdata,
    input  logic                      s_axis_tlast,   // last
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // [31:0] hash_value
    output logic [sfh_pkg::HashW-1:0] m_axis_tdata
);

    // Input register stage
    logic                   r_s1_valid;
    logic                   r_s1_last;
    sfh_pkg::t_byte         r_b0, r_b1, r_b2, r_b3;
    sfh_pkg::t_count        r_cnt;

    // Running hash and result register
    sfh_pkg::t_hash         r_hash;
    logic                   r_out_valid;
    sfh_pkg::t_hash         r_out_data;

    logic                   s_fire;
    logic                   s1_fire;
    logic                   out_free;
    logic                   full_chunk;
    sfh_pkg::t_hash         n_mixed;
    sfh_pkg::t_hash         n_final;

    // A last item needs a free result slot; other items move on at once.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s1_fire       = r_s1_valid && (!r_s1_last || out_free);
    assign s_axis_tready = !r_s1_valid || s1_fire;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // Counts 4..7 all mean a full chunk.
    assign full_chunk = r_cnt[2];

    always_comb begin
        if (full_chunk) begin
            n_mixed = sfh_pkg::mix_chunk(r_hash, r_b0, r_b1, r_b2, r_b3);
        end else begin
            n_mixed = sfh_pkg::mix_tail(r_hash, r_cnt[1:0], r_b0, r_b1, r_b2);
        end
        n_final = sfh_pkg::avalanche(n_mixed);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_b0      <= s_axis_tdata[7:0];
            r_b1      <= s_axis_tdata[15:8];
            r_b2      <= s_axis_tdata[23:16];
            r_b3      <= s_axis_tdata[31:24];
            r_cnt     <= s_axis_tdata[34:32];
            r_s1_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= '0;
        end else if (s1_fire) begin
            if (r_s1_last) begin
                r_hash <= '0;
            end else if (full_chunk) begin
                r_hash <= n_mixed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_last) begin
            r_out_data <= n_final;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `SFH_ASSERT_SAME(a_last_waits, i_clk, i_rst_n, r_out_valid && !m_axis_tready && r_s1_valid && r_s1_last, !s_axis_tready, "last item advanced into a stalled result register")
    `SFH_ASSERT_NEXT(a_hash_clears, i_clk, i_rst_n, s1_fire && r_s1_last, r_hash == '0, "running hash not cleared after last item")
    `SFH_ASSERT_NEXT(a_result_source, i_clk, i_rst_n, !(s1_fire && r_s1_last) && !(r_out_valid && !m_axis_tready), !r_out_valid, "result appeared without a last item")

endmodule

// ===== tb/superfast_string_hash_core_test.sv =====
// Self-checking testbench for superfast_string_hash_core: a scoreboard class predicts each
// string hash; tasks drive s_axis, hash_sink drives m_axis; random idling and backpressure.
// Depends on sfh_pkg (widths and types) and the core itself.

module superfast_string_hash_core_test;

    // Watchdog limit in cycles without any accepted item.
    // The longest honest pause is the forced hold-off of the output side.
    localparam int unsigned IdleLimit   = 3000;
    localparam int unsigned HoldCycles  = 200;    // long output hold-off
    localparam int unsigned TotalItems  = 1250;   // input items over the whole run
    localparam int unsigned DrainCycles = 10;     // settle time after the last hash
    localparam int unsigned MaxGap      = 19;
    localparam int unsigned FullCount   = 4;      // bytes in a full chunk

    // Predictor of the running hash plus the queue of finished hashes still due.
    class hash_scoreboard;
        sfh_pkg::t_hash running_sum;
        sfh_pkg::t_hash expected_hashes[$];
        int unsigned    mismatches;

        function new();
            running_sum = '0;
            mismatches  = 0;
        endfunction

        // 16-bit half, first byte on top
        function sfh_pkg::t_hash half_word(sfh_pkg::t_byte hi, sfh_pkg::t_byte lo);
            return {16'h0000, hi, lo};
        endfunction

        function sfh_pkg::t_hash chunk_mix(sfh_pkg::t_hash h, sfh_pkg::t_byte b0,
                                           sfh_pkg::t_byte b1, sfh_pkg::t_byte b2,
                                           sfh_pkg::t_byte b3);
            sfh_pkg::t_hash t;
            h = h + half_word(b0, b1);
            t = (half_word(b2, b3) << 11) ^ h;
            h = (h << 16) ^ t;
            h = h + (h >> 11);
            return h;
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            mismatches++;
        endtask

        // Called for every accepted input item.
        task note_input(sfh_pkg::t_byte b0, sfh_pkg::t_byte b1, sfh_pkg::t_byte b2,
                        sfh_pkg::t_byte b3, sfh_pkg::t_count cnt, logic is_last);
            int unsigned    n;
            sfh_pkg::t_hash h;
            n = 32'(cnt);
            if (n > FullCount)
                n = FullCount;
            h = running_sum;
            if (!is_last) begin
                // short non-final chunks are dropped
                if (n == FullCount)
                    running_sum = chunk_mix(h, b0, b1, b2, b3);
                return;
            end
            case (n)
                4: begin
                    h = chunk_mix(h, b0, b1, b2, b3);
                end
                3: begin
                    h = h + half_word(b0, b1);
                    h = h ^ (h << 16);
                    h = h ^ ({24'h000000, b2} << 18);
                    h = h + (h >> 11);
                end
                2: begin
                    h = h + half_word(b0, b1);
                    h = h ^ (h << 11);
                    h = h + (h >> 17);
                end
                1: begin
                    h = h + {24'h000000, b0};
                    h = h ^ (h << 10);
                    h = h + (h >> 1);
                end
                default: begin
                end
            endcase
            // avalanche
            h = h ^ (h << 3);
            h = h + (h >> 5);
            h = h ^ (h << 2);
            h = h + (h >> 15);
            h = h ^ (h << 10);
            expected_hashes.push_back(h);
            running_sum = '0;
        endtask

        // Called for every accepted hash.
        task check_result(sfh_pkg::t_hash got);
            sfh_pkg::t_hash want;
            if (expected_hashes.size() == 0) begin
                report($sformatf("hash %h arrived with none pending", got));
                return;
            end
            want = expected_hashes.pop_front();
            if (got !== want)
                report($sformatf("hash_value got %h want %h", got, want));
        endtask
    endclass

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // DUT ports; every input starts at a known value
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    // [7:0] first_byte, [15:8] second_byte, [23:16] third_byte,
    // [31:24] fourth_byte, [34:32] byte_count, [39:35] zero
    logic [sfh_pkg::InTdW-1:0] s_axis_tdata  = '0;
    logic                      s_axis_tlast  = 1'b0;   // last
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    // [31:0] hash_value
    logic [sfh_pkg::HashW-1:0] m_axis_tdata;

    superfast_string_hash_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    hash_scoreboard sb;

    // Shared knobs between the input driver and the output side.
    bit          send_calm;     // sender runs without gaps for a while
    bit          gapless;       // forced back-to-back items (pressure phase)
    bit          hold_request;  // asks the output side for one long hold-off
    int unsigned counted_items;

    // Monitor: sample both handshakes at the edge, values are pre-update here.
    // Also the watchdog: too long without any accepted item ends the run.
    int unsigned idle_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16],
                              s_axis_tdata[31:24], s_axis_tdata[34:32], s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles + 1 >= IdleLimit) begin
                    $display("watchdog: no item accepted for %0d cycles", IdleLimit);
                    $display("[superfast_string_hash_core] ERROR");
                    $finish;
                end
            end
        end
    end

    function automatic int unsigned next_gap();
        if (gapless || send_calm)
            return 0;
        return $urandom_range(0, MaxGap);
    endfunction

    function automatic sfh_pkg::t_byte rand_byte();
        return sfh_pkg::t_byte'($urandom);
    endfunction

    // One item on s_axis; returns at the edge where it is taken.
    // tvalid is only dropped when a gap is actually wanted, so back-to-back
    // items never see a low/high pair in the same step.
    task automatic send_chunk(input sfh_pkg::t_byte b0, input sfh_pkg::t_byte b1,
                              input sfh_pkg::t_byte b2, input sfh_pkg::t_byte b3,
                              input sfh_pkg::t_count cnt, input logic is_last);
        int unsigned gap;
        gap = next_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(sfh_pkg::InTdW-sfh_pkg::InW){1'b0}}, cnt, b3, b2, b1, b0};
        s_axis_tlast  <= is_last;
        do @(posedge i_clk); while (!s_axis_tready);
        counted_items++;
    endtask

    // Full chunks with random bytes, then a final item with the given count.
    task automatic send_string(input int unsigned chunks, input sfh_pkg::t_count tail_count);
        repeat (chunks)
            send_chunk(rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                       sfh_pkg::t_count'(FullCount), 1'b0);
        send_chunk(rand_byte(), rand_byte(), rand_byte(), rand_byte(), tail_count, 1'b1);
    endtask

    // Output side: random stall before each hash, calm stretches, and one
    // long hold-off on request while the sender keeps pushing.
    initial begin : hash_sink
        int unsigned stall;
        bit          recv_calm;
        bit          held;
        recv_calm = 1'b0;
        held      = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_request && !held) begin
                m_axis_tready <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
                held = 1'b1;
            end
            if ($urandom_range(0, 31) == 0)
                recv_calm = !recv_calm;
            stall = recv_calm ? 0 : $urandom_range(0, MaxGap);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin : stimulus
        int unsigned pick;
        sb            = new();
        send_calm     = 1'b0;
        gapless       = 1'b0;
        hold_request  = 1'b0;
        counted_items = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part
        // empty strings, one with junk bytes that must be ignored -> hash 0
        send_chunk(8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 1'b1);
        send_chunk(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd0, 1'b1);
        // tails of one, two and three bytes at both byte extremes
        send_chunk(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd1, 1'b1);
        send_chunk(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd2, 1'b1);
        send_chunk(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd3, 1'b1);
        send_chunk(8'h00, 8'h00, 8'h00, 8'hFF, 3'd3, 1'b1);
        send_chunk(8'h01, 8'h00, 8'h00, 8'h00, 3'd1, 1'b1);
        // full final chunk, and counts above four that saturate to four
        send_chunk(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd4, 1'b1);
        send_chunk(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd5, 1'b1);
        send_chunk(8'hA5, 8'h5A, 8'hC3, 8'h3C, 3'd6, 1'b1);
        send_chunk(8'h80, 8'h7F, 8'h01, 8'hFE, 3'd7, 1'b1);
        // short non-final chunks are dropped: the empty end still hashes to 0
        send_chunk(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd0, 1'b0);
        send_chunk(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd1, 1'b0);
        send_chunk(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd2, 1'b0);
        send_chunk(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd3, 1'b0);
        send_chunk(8'h12, 8'h34, 8'h56, 8'h78, 3'd0, 1'b1);
        // multi-chunk string mixing saturated and dropped chunks, three-byte tail
        send_chunk(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7, 1'b0);
        send_chunk(8'h00, 8'h00, 8'h00, 8'h00, 3'd4, 1'b0);
        send_chunk(8'hDE, 8'hAD, 8'hBE, 8'hEF, 3'd2, 1'b0);
        send_chunk(8'h5A, 8'hA5, 8'h5A, 8'hA5, 3'd5, 1'b0);
        send_chunk(8'hFF, 8'h00, 8'hFF, 8'h00, 3'd3, 1'b1);
        // long all-ones string ending with a full final chunk
        repeat (3) send_chunk(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd4, 1'b0);
        send_chunk(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd4, 1'b1);

        // Pressure: output held off while short strings go in back to back,
        // so the core fills up and drops s_axis_tready.
        hold_request = 1'b1;
        gapless      = 1'b1;
        repeat (40) send_string($urandom_range(0, 1), sfh_pkg::t_count'($urandom_range(0, 4)));
        gapless      = 1'b0;

        // Random part: mostly well-formed strings, some noise items between them
        while (counted_items < TotalItems) begin
            if ($urandom_range(0, 15) == 0)
                send_calm = !send_calm;
            pick = $urandom_range(0, 9);
            case (pick)
                0: begin
                    // stray non-final chunk with any count
                    send_chunk(rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                               sfh_pkg::t_count'($urandom_range(0, 7)), 1'b0);
                end
                9: begin
                    send_string($urandom_range(6, 24),
                                sfh_pkg::t_count'($urandom_range(0, 7)));
                end
                default: begin
                    send_string($urandom_range(0, 5),
                                sfh_pkg::t_count'($urandom_range(0, 7)));
                end
            endcase
        end

        // Drain: wait for every pending hash, then the settle time
        s_axis_tvalid <= 1'b0;
        while (sb.expected_hashes.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (sb.mismatches == 0)
            $display("[superfast_string_hash_core] OK");
        else
            $display("[superfast_string_hash_core] ERROR");
        $finish;
    end

endmodule
